// File: hw/rtl/c8pf_pkg.sv
`timescale 1ns / 1ps
package c8pf_pkg;

  localparam int MaxMessage   = 28;
  localparam int BurstMax     = 5;
  localparam int CntW         = 3;

  localparam logic [7:0] Preamble     = 8'hAA;
  localparam logic [7:0] CrcPoly      = 8'h07;
  localparam logic [4:0] DefaultLimit = 5'd16;
  localparam logic [7:0] IdCritA      = 8'h10;
  localparam logic [7:0] IdCritB      = 8'h11;
  localparam logic [7:0] IdCritC      = 8'h13;

  typedef enum logic [1:0] {
    StFrame   = 2'd0,
    StTooLong = 2'd1,
    StBusy    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic [4:0] msg_length;
    logic       link_ready;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last_of_run;
  } out_req_t;

  typedef struct packed {
    out_req_t [BurstMax-1:0] res;
    logic [CntW-1:0]         count;
  } burst_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/c8pf_burst_buf.sv
`timescale 1ns / 1ps
module c8pf_burst_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  c8pf_pkg::burst_t  burst_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output c8pf_pkg::out_req_t out_req_o
);
  import c8pf_pkg::*;

  out_req_t [BurstMax-1:0] res_q, res_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    take;

  assign out_valid_o = (cnt_q != '0);
  assign out_req_o   = res_q[0];
  assign take        = out_valid_o && !out_stall_i;
  assign can_load_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !out_stall_i);

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (load_i) begin
      res_d = burst_i.res;
      cnt_d = burst_i.count;
    end else if (take) begin
      for (int i = 0; i < BurstMax - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// File: hw/rtl/crc8_packet_framer.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_stall_o | in_req_i  (msg_byte, msg_length, link_ready)
// out      | output    | out_valid_o/out_stall_i | out_req_o (out_byte, status, last_of_run)
// cfg      | input     | cfg_we_i                | cfg_wdata_i (payload_limit)
//
// Each request is evaluated in the cycle it is accepted; its 0 to 5 results are
// loaded into a result buffer and leave one per cycle while out_stall_i is low.
// in_stall_o is high while more than one result is queued, or one is queued and
// out_stall_i holds it.
// Reset clears sequence, CRC, position and drop state and sets the limit to 16.
module crc8_packet_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  c8pf_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output c8pf_pkg::out_req_t out_req_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i
);
  import c8pf_pkg::*;

  logic [4:0] limit_q;
  logic [7:0] seq_q, seq_d;
  logic [7:0] crc_q, crc_d;
  logic [4:0] pos_q, pos_d;
  logic       drop_q, drop_d;

  logic       can_load, accept;
  burst_t     burst;

  logic       first, too_long, critical, busy, ends;
  logic [4:0] lim, len;
  logic [7:0] b, flen, crc_base, crc_new;

  assign accept     = in_valid_i && can_load;
  assign in_stall_o = !can_load;

  assign b        = in_req_i.msg_byte;
  assign len      = in_req_i.msg_length;
  assign first    = (pos_q == '0);
  assign lim      = (limit_q == '0) ? DefaultLimit : limit_q;
  assign too_long = (len == '0) || (len > lim) || ({3'b000, len} > 8'(MaxMessage));
  assign critical = (b == IdCritA) || (b == IdCritB) || (b == IdCritC);
  assign busy     = !in_req_i.link_ready && !critical;
  assign ends     = ({1'b0, pos_q} + 6'd1) >= {1'b0, len};
  assign flen     = {3'b000, len} + 8'd1;
  assign crc_base = first ? crc8_update(crc8_update(8'h00, flen), seq_q) : crc_q;
  assign crc_new  = crc8_update(crc_base, b);

  always_comb begin
    burst  = '0;
    seq_d  = seq_q;
    crc_d  = crc_q;
    pos_d  = pos_q;
    drop_d = drop_q;
    if (first && (too_long || busy)) begin
      burst.res[0].status = too_long ? StTooLong : StBusy;
      burst.count         = CntW'(1);
      if (len > 5'd1) begin
        drop_d = 1'b1;
        pos_d  = 5'd1;
      end else begin
        drop_d = 1'b0;
      end
    end else if (first) begin
      drop_d              = 1'b0;
      burst.res[0].out_byte = Preamble;
      burst.res[1].out_byte = flen;
      burst.res[2].out_byte = seq_q;
      burst.res[3].out_byte = b;
      seq_d               = seq_q + 8'd1;
      crc_d               = crc_new;
      if (ends) begin
        burst.res[4].out_byte = crc_new;
        burst.count           = CntW'(5);
        pos_d                 = '0;
      end else begin
        burst.count = CntW'(4);
        pos_d       = pos_q + 5'd1;
      end
    end else if (drop_q) begin
      if (ends) begin
        pos_d  = '0;
        drop_d = 1'b0;
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end else begin
      burst.res[0].out_byte = b;
      crc_d                 = crc_new;
      if (ends) begin
        burst.res[1].out_byte = crc_new;
        burst.count           = CntW'(2);
        pos_d                 = '0;
      end else begin
        burst.count = CntW'(1);
        pos_d       = pos_q + 5'd1;
      end
    end
    for (int i = 0; i < BurstMax; i++) begin
      burst.res[i].last_of_run = (CntW'(i + 1) == burst.count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DefaultLimit;
      seq_q   <= '0;
      crc_q   <= '0;
      pos_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        seq_q  <= seq_d;
        crc_q  <= crc_d;
        pos_q  <= pos_d;
        drop_q <= drop_d;
      end
    end
  end

  c8pf_burst_buf u_burst_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
